>>> rtl/tlc_pkg.sv
// Shared types, constants and helper functions of the two-road traffic light unit.
// Used by tlc_road and two_road_traffic_light_countdown_unit; depends on nothing.
package tlc_pkg;

  localparam int unsigned MS_W    = 17;
  localparam int unsigned SCAN_W  = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned RLD_W   = 7;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [MS_W-1:0]   MS_MAX   = '1;
  localparam logic [SCAN_W-1:0] SCAN_MAX = '1;

  localparam logic [MS_W-1:0]   RED_MS_RST    = 17'd31000;
  localparam logic [MS_W-1:0]   YELLOW_MS_RST = 17'd3000;
  localparam logic [MS_W-1:0]   GREEN_MS_RST  = 17'd28000;
  localparam logic [SCAN_W-1:0] SCAN_MS_RST   = 8'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_RED_MS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MS   = 2'd3;

  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h7F;

  localparam logic signed [CNT_W-1:0] CNT_FLOOR = -8'sd128;
  localparam logic signed [CNT_W-1:0] CNT_TOP   = 8'sd99;

  // Active-low patterns for the digits zero to nine; unused codes are blank.
  localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78,
    7'h00, 7'h10, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F
  };

  typedef enum logic [1:0] {
    LIGHT_RED    = 2'd0,
    LIGHT_YELLOW = 2'd1,
    LIGHT_GREEN  = 2'd2
  } light_t;

  typedef enum logic [1:0] {
    DIGIT_NONE = 2'd0,
    DIGIT_TENS = 2'd1,
    DIGIT_ONES = 2'd2
  } digit_sel_t;

  typedef struct packed {
    logic [MS_W-1:0]  red_ms;
    logic [MS_W-1:0]  yellow_ms;
    logic [MS_W-1:0]  green_ms;
    logic [RLD_W-1:0] red_reload;
    logic [RLD_W-1:0] green_reload;
  } road_cfg_t;

  typedef struct packed {
    light_t                    light;
    logic signed [CNT_W-1:0]   countdown;
    logic                      show;
  } road_stat_t;

  // Maps the whole-seconds quotient of a phase length to its countdown start.
  function automatic logic [RLD_W-1:0] reload_clamp(input logic [MS_W-1:0] q);
    logic [RLD_W-1:0] r;
    if (q == '0) begin
      r = '0;
    end else if (q > 17'd100) begin
      r = 7'd99;
    end else begin
      r = RLD_W'(q - 17'd1);
    end
    return r;
  endfunction

  // Segment pattern of one road for the tens or the ones digit.
  function automatic logic [SEG_W-1:0] road_segs(input road_stat_t s, input logic ones);
    logic [6:0]  v;
    logic [15:0] prod;
    logic [3:0]  tens;
    logic [6:0]  low;
    logic [3:0]  digit;
    logic [SEG_W-1:0] segs;
    v    = s.countdown[6:0];
    // Multiplying by 205/2048 gives the exact tens digit for values up to 99.
    prod = 16'(v) * 16'd205;
    tens = prod[14:11];
    low  = 7'(v - 7'(tens) * 7'd10);
    digit = ones ? low[3:0] : tens;
    if (!s.show || s.countdown < 0 || s.countdown > CNT_TOP) begin
      segs = SEG_BLANK;
    end else begin
      segs = SEG_TABLE[digit];
    end
    return segs;
  endfunction

endpackage

>>> rtl/two_road_traffic_light_countdown_unit.sv
// Top level of the two-road traffic light unit with countdown display.
// Depends on tlc_pkg and instantiates tlc_road once for each road.
//
// Each accepted input word is one millisecond tick (advance set) or a plain
// status request (advance clear); every input word yields exactly one result
// word with both lamp states, both roads' latched active-low segment patterns
// and the shared digit select. The block takes one input word per clock while
// results are taken: all per-tick work is a single pass of counters and
// compares from the state registers into the output register, and a new word
// is taken in the same cycle that the waiting result is taken. The result is
// registered and valid in the cycle after acceptance. The countdown start
// values are derived from the red and green lengths on the configuration write
// itself, through a reciprocal multiply by the ticks-per-second constant, so a
// new length can be followed by a tick in the very next cycle.
module two_road_traffic_light_countdown_unit #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_advance,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_road_one_light,
  output logic [1:0]                          out_road_two_light,
  output logic [tlc_pkg::SEG_W-1:0]           out_road_one_segments,
  output logic [tlc_pkg::SEG_W-1:0]           out_road_two_segments,
  output logic [1:0]                          out_digit_select,
  input  logic                                cfg_we,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tlc_pkg::MS_W-1:0]            cfg_wdata
);

  // Exact floor division of a 17-bit length by the tick rate: multiply by the
  // rounded-up reciprocal and drop the fraction bits.
  localparam int unsigned DIV_L     = $clog2(TICKS_PER_SECOND);
  localparam int unsigned DIV_SHIFT = tlc_pkg::MS_W + DIV_L;
  localparam int unsigned RECIP_W   = tlc_pkg::MS_W + 2;
  localparam int unsigned PROD_W    = tlc_pkg::MS_W + RECIP_W;
  localparam logic [63:0] DIV_RECIP64 =
    ((64'd1 << DIV_SHIFT) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);
  localparam logic [RECIP_W-1:0] DIV_RECIP = DIV_RECIP64[RECIP_W-1:0];

  localparam logic [tlc_pkg::MS_W-1:0] RED_RST_Q =
    tlc_pkg::MS_W'(31000 / TICKS_PER_SECOND);
  localparam logic [tlc_pkg::MS_W-1:0] GREEN_RST_Q =
    tlc_pkg::MS_W'(28000 / TICKS_PER_SECOND);
  localparam logic [tlc_pkg::RLD_W-1:0] RED_RST_RLD   = tlc_pkg::reload_clamp(RED_RST_Q);
  localparam logic [tlc_pkg::RLD_W-1:0] GREEN_RST_RLD = tlc_pkg::reload_clamp(GREEN_RST_Q);

  logic [tlc_pkg::MS_W-1:0]   red_ms_r, yellow_ms_r, green_ms_r;
  logic [tlc_pkg::SCAN_W-1:0] scan_ms_r;
  logic [tlc_pkg::RLD_W-1:0]  red_rld_r, green_rld_r;

  logic [PROD_W-1:0]          div_prod;
  logic [tlc_pkg::MS_W-1:0]   div_q;
  logic [tlc_pkg::RLD_W-1:0]  wr_rld;

  tlc_pkg::road_cfg_t  road_cfg;
  tlc_pkg::road_stat_t one_nxt, two_nxt;

  logic                        accept;
  logic                        tick;
  logic [tlc_pkg::SCAN_W-1:0]  scan_r, scan_nxt;
  logic                        ones_r, ones_nxt;
  logic [tlc_pkg::SEG_W-1:0]   one_segs_r, one_segs_nxt;
  logic [tlc_pkg::SEG_W-1:0]   two_segs_r, two_segs_nxt;
  tlc_pkg::digit_sel_t         sel_r, sel_nxt;
  logic                        out_valid_r;

  logic [1:0]                  out_one_light_r, out_two_light_r;
  logic [tlc_pkg::SEG_W-1:0]   out_one_segs_r, out_two_segs_r;
  logic [1:0]                  out_sel_r;

  // Configuration registers and countdown start values.
  assign div_prod = PROD_W'(cfg_wdata) * PROD_W'(DIV_RECIP);
  assign div_q    = tlc_pkg::MS_W'(div_prod >> DIV_SHIFT);
  assign wr_rld   = tlc_pkg::reload_clamp(div_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_ms_r    <= tlc_pkg::RED_MS_RST;
      yellow_ms_r <= tlc_pkg::YELLOW_MS_RST;
      green_ms_r  <= tlc_pkg::GREEN_MS_RST;
      scan_ms_r   <= tlc_pkg::SCAN_MS_RST;
      red_rld_r   <= RED_RST_RLD;
      green_rld_r <= GREEN_RST_RLD;
    end else if (cfg_we) begin
      case (cfg_index)
        tlc_pkg::CFG_RED_MS: begin
          red_ms_r  <= cfg_wdata;
          red_rld_r <= wr_rld;
        end
        tlc_pkg::CFG_YELLOW_MS: begin
          yellow_ms_r <= cfg_wdata;
        end
        tlc_pkg::CFG_GREEN_MS: begin
          green_ms_r  <= cfg_wdata;
          green_rld_r <= wr_rld;
        end
        tlc_pkg::CFG_SCAN_MS: begin
          scan_ms_r <= cfg_wdata[tlc_pkg::SCAN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign road_cfg.red_ms       = red_ms_r;
  assign road_cfg.yellow_ms    = yellow_ms_r;
  assign road_cfg.green_ms     = green_ms_r;
  assign road_cfg.red_reload   = red_rld_r;
  assign road_cfg.green_reload = green_rld_r;

  // Handshake: the output register frees up in the cycle its word is taken.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign tick     = accept && in_advance;

  tlc_road #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .INIT_LIGHT       (tlc_pkg::LIGHT_RED),
    .INIT_COUNT       (int'(RED_RST_RLD))
  ) u_road_one (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (tick),
    .cfg      (road_cfg),
    .stat_nxt (one_nxt)
  );

  tlc_road #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .INIT_LIGHT       (tlc_pkg::LIGHT_GREEN),
    .INIT_COUNT       (int'(GREEN_RST_RLD))
  ) u_road_two (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (tick),
    .cfg      (road_cfg),
    .stat_nxt (two_nxt)
  );

  // Display scan: patterns are taken from the road state after this tick.
  always_comb begin
    scan_nxt     = scan_r;
    ones_nxt     = ones_r;
    one_segs_nxt = one_segs_r;
    two_segs_nxt = two_segs_r;
    sel_nxt      = sel_r;
    if (tick) begin
      scan_nxt = (scan_r == tlc_pkg::SCAN_MAX) ? scan_r : scan_r + 8'd1;
      if (scan_nxt >= scan_ms_r) begin
        one_segs_nxt = tlc_pkg::road_segs(one_nxt, ones_r);
        two_segs_nxt = tlc_pkg::road_segs(two_nxt, ones_r);
        sel_nxt      = ones_r ? tlc_pkg::DIGIT_ONES : tlc_pkg::DIGIT_TENS;
        ones_nxt     = !ones_r;
        scan_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      ones_r      <= 1'b0;
      one_segs_r  <= '0;
      two_segs_r  <= '0;
      sel_r       <= tlc_pkg::DIGIT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      scan_r     <= scan_nxt;
      ones_r     <= ones_nxt;
      one_segs_r <= one_segs_nxt;
      two_segs_r <= two_segs_nxt;
      sel_r      <= sel_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_one_light_r <= one_nxt.light;
      out_two_light_r <= two_nxt.light;
      out_one_segs_r  <= one_segs_nxt;
      out_two_segs_r  <= two_segs_nxt;
      out_sel_r       <= sel_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_road_one_light    = out_one_light_r;
  assign out_road_two_light    = out_two_light_r;
  assign out_road_one_segments = out_one_segs_r;
  assign out_road_two_segments = out_two_segs_r;
  assign out_digit_select      = out_sel_r;

`ifndef SYNTHESIS
  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word did not produce a valid result");

  a_status_only_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_advance) |=> ($stable(sel_r) && $stable(one_segs_r)
                                 && $stable(two_segs_r) && $stable(scan_r)))
    else $error("status request changed the display state");

  a_digit_never_returns_to_none: assert property (@(posedge clk) disable iff (!rst_n)
    (sel_r != tlc_pkg::DIGIT_NONE) |=> (sel_r != tlc_pkg::DIGIT_NONE))
    else $error("digit select fell back to none");

  a_countdown_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (one_nxt.countdown <= tlc_pkg::CNT_TOP) && (two_nxt.countdown <= tlc_pkg::CNT_TOP))
    else $error("countdown above 99");
`endif

endmodule

>>> rtl/tlc_road.sv
// One road of the traffic light unit: light phase, timers and seconds countdown.
// Depends on tlc_pkg for the light codes, configuration and status structs.
module tlc_road #(
  parameter int unsigned     TICKS_PER_SECOND = 1000,
  parameter tlc_pkg::light_t INIT_LIGHT       = tlc_pkg::LIGHT_RED,
  parameter int              INIT_COUNT       = 30
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tick,
  input  tlc_pkg::road_cfg_t  cfg,
  output tlc_pkg::road_stat_t stat_nxt
);

  localparam logic [tlc_pkg::MS_W-1:0] SEC_LIMIT = tlc_pkg::MS_W'(TICKS_PER_SECOND);

  tlc_pkg::light_t                   light_r, light_nxt;
  logic [tlc_pkg::MS_W-1:0]          sec_r, sec_nxt;
  logic [tlc_pkg::MS_W-1:0]          phase_r, phase_nxt;
  logic signed [tlc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                              show_r, show_nxt;
  logic signed [tlc_pkg::CNT_W-1:0]  cnt_dec;

  assign cnt_dec = (cnt_r != tlc_pkg::CNT_FLOOR) ? cnt_r - 8'sd1 : cnt_r;

  always_comb begin
    light_nxt = light_r;
    sec_nxt   = sec_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    show_nxt  = show_r;
    if (tick) begin
      sec_nxt   = (sec_r == tlc_pkg::MS_MAX) ? sec_r : sec_r + 17'd1;
      phase_nxt = (phase_r == tlc_pkg::MS_MAX) ? phase_r : phase_r + 17'd1;
      case (light_r)
        tlc_pkg::LIGHT_GREEN: begin
          if (sec_nxt >= SEC_LIMIT) begin
            cnt_nxt = cnt_dec;
            if (cnt_dec < 0) begin
              show_nxt = 1'b0;
            end
            sec_nxt = '0;
          end
          if (phase_nxt >= cfg.green_ms) begin
            light_nxt = tlc_pkg::LIGHT_YELLOW;
            phase_nxt = '0;
          end
        end
        tlc_pkg::LIGHT_YELLOW: begin
          // The second timer runs on from green, so this can fire early.
          if (sec_nxt >= cfg.yellow_ms) begin
            show_nxt = 1'b1;
            cnt_nxt  = $signed({1'b0, cfg.red_reload});
            sec_nxt  = '0;
          end
          if (phase_nxt >= cfg.yellow_ms) begin
            light_nxt = tlc_pkg::LIGHT_RED;
            phase_nxt = '0;
          end
        end
        default: begin
          if (sec_nxt >= SEC_LIMIT) begin
            cnt_nxt = (cnt_dec < 0) ? $signed({1'b0, cfg.green_reload}) : cnt_dec;
            sec_nxt = '0;
          end
          if (phase_nxt >= cfg.red_ms) begin
            light_nxt = tlc_pkg::LIGHT_GREEN;
            phase_nxt = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r <= INIT_LIGHT;
      sec_r   <= '0;
      phase_r <= '0;
      cnt_r   <= tlc_pkg::CNT_W'(INIT_COUNT);
      show_r  <= 1'b1;
    end else begin
      light_r <= light_nxt;
      sec_r   <= sec_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      show_r  <= show_nxt;
    end
  end

  assign stat_nxt.light     = light_nxt;
  assign stat_nxt.countdown = cnt_nxt;
  assign stat_nxt.show      = show_nxt;

endmodule
